/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/hlat_pkg.sv */
// ----------------------------------------------------------------------------
// hlat_pkg
// Sizes, types and helper functions of the host location table.
// ----------------------------------------------------------------------------
package hlat_pkg;

	localparam int HOST_ROWS      = 64;
	localparam int SLOTS_PER_HOST = 4;
	localparam int NSLOTS         = HOST_ROWS * SLOTS_PER_HOST;
	localparam int ROW_W          = (HOST_ROWS > 1) ? $clog2(HOST_ROWS) : 1;
	localparam int ROWC_W         = $clog2(HOST_ROWS + 1);
	localparam int SLOT_W         = (SLOTS_PER_HOST > 1) ? $clog2(SLOTS_PER_HOST) : 1;
	localparam int SC_W           = $clog2(SLOTS_PER_HOST + 1);
	localparam int SIDX_W         = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_ADDED    = 2'd1,
		EV_MODIFIED = 2'd2,
		EV_REMOVED  = 2'd3
	} ev_t;

	localparam logic REG_MAX_BINDINGS = 1'b0;
	localparam logic REG_TIMEOUT      = 1'b1;

	typedef struct packed {
		logic [63:0] sw;
		logic [15:0] port;
		logic [31:0] seen;
	} slot_word_t;

	typedef struct packed {
		logic              rh_we;
		logic [ROW_W-1:0]  rh_waddr;
		logic [31:0]       rh_wdata;
		logic [ROW_W-1:0]  rh_raddr;
		logic              sl_we;
		logic [SIDX_W-1:0] sl_waddr;
		slot_word_t        sl_wdata;
		logic [SIDX_W-1:0] sl_raddr;
	} store_req_t;

	typedef struct packed {
		logic match;
		logic older;
		logic newer;
		logic expired;
	} cmp_res_t;

	typedef struct packed {
		ev_t         ev;
		logic [31:0] host;
		logic        found;
		slot_word_t  loc;
		logic [9:0]  expired;
		logic        full;
		logic        last;
	} result_t;

	function automatic logic [SIDX_W-1:0] sidx(logic [ROW_W-1:0] r, logic [SLOT_W-1:0] s);
		return SIDX_W'(r) * SIDX_W'(SLOTS_PER_HOST) + SIDX_W'(s);
	endfunction

	function automatic logic [SC_W-1:0] popcount(logic [SLOTS_PER_HOST-1:0] v);
		logic [SC_W-1:0] n;
		n = '0;
		for (int j = 0; j < SLOTS_PER_HOST; j++)
			n = n + SC_W'(v[j]);
		return n;
	endfunction

	function automatic logic [SLOT_W-1:0] first_zero(logic [SLOTS_PER_HOST-1:0] v);
		logic [SLOT_W-1:0] p;
		p = '0;
		for (int j = SLOTS_PER_HOST - 1; j >= 0; j--)
			if (!v[j])
				p = SLOT_W'(j);
		return p;
	endfunction

	function automatic result_t mk_res(ev_t ev, logic [31:0] host, logic found,
			slot_word_t w, logic [9:0] expired, logic full, logic last);
		result_t r;
		r.ev      = ev;
		r.host    = host;
		r.found   = found;
		r.loc     = found ? w : '0;
		r.expired = expired;
		r.full    = full;
		r.last    = last;
		return r;
	endfunction

endpackage

/* rtl/hlat_cmp.sv */
// ----------------------------------------------------------------------------
// hlat_cmp
// Shared compare unit: matches, age ordering and expiry of one slot.
// ----------------------------------------------------------------------------
module hlat_cmp import hlat_pkg::*; (
	input  slot_word_t  word,
	input  logic [63:0] sw,
	input  logic [15:0] port,
	input  logic [31:0] best_time,
	input  logic [15:0] timeout,
	input  logic [31:0] now,
	output cmp_res_t    res
);

	logic [32:0] limit_time;

	assign limit_time  = {1'b0, word.seen} + {17'b0, timeout};
	assign res.match   = (word.sw == sw) && (word.port == port);
	assign res.older   = word.seen < best_time;
	assign res.newer   = word.seen > best_time;
	assign res.expired = limit_time < {1'b0, now};

endmodule

/* rtl/hlat_store.sv */
// ----------------------------------------------------------------------------
// hlat_store
// Host address memory and slot location memory, registered reads.
// ----------------------------------------------------------------------------
module hlat_store import hlat_pkg::*; (
	input  logic        clk,
	input  store_req_t  req,
	output logic [31:0] rh_rdata,
	output slot_word_t  sl_rdata
);

	logic [31:0] row_host_mem [HOST_ROWS];
	slot_word_t  slot_mem [NSLOTS];

	always_ff @(posedge clk) begin
		if (req.rh_we)
			row_host_mem[req.rh_waddr] <= req.rh_wdata;
		rh_rdata <= row_host_mem[req.rh_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.sl_we)
			slot_mem[req.sl_waddr] <= req.sl_wdata;
		sl_rdata <= slot_mem[req.sl_raddr];
	end

endmodule

/* rtl/host_location_aging_table_top.sv */
// ----------------------------------------------------------------------------
// host_location_aging_table_top
// Host location table with per-host eviction and timed expiry.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/stall) and results leave on the
// out_ channel; a request is taken when in_valid is high and in_stall low.
// The block handles one request at a time and holds in_stall high until its
// last result has been taken. Add, remove and query first walk the host rows,
// skipping each empty row and reading then comparing the host of each valid
// row; once the host is found they walk the slots of its row, skipping each
// empty slot, reading then comparing each valid slot, and closing the pass in
// a final step; an add repeats the pass once per evicted location. A tick
// skips each empty row and enters each valid row to run the slot pass on it.
// Each reported location is read, loaded into the output register and held
// there until the receiver takes it; empty slots on the way are skipped.
// The pace is set by the single read port of the slot memory and the one
// shared compare unit. A stalled result is held in the output register.
// Reset empties the table, sets max_bindings to 1 and the timeout to 60 s.
// Registers sit on the APB port at byte addresses 0 and 4.
// ----------------------------------------------------------------------------
module host_location_aging_table_top import hlat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] host_ip,
	input  logic [63:0] switch_id,
	input  logic [15:0] port_num,
	input  logic [31:0] entry_time,
	input  logic [31:0] current_time,
	input  logic        post_event,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [31:0] host_out,
	output logic        found,
	output logic [63:0] switch_out,
	output logic [15:0] port_out,
	output logic [31:0] time_out,
	output logic [9:0]  expired_count,
	output logic        table_full,
	output logic        last
);

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_FIND_RD  = 11'b00000000010,
		ST_FIND_CMP = 11'b00000000100,
		ST_NEWROW   = 11'b00000001000,
		ST_SCAN_RD  = 11'b00000010000,
		ST_SCAN_CMP = 11'b00000100000,
		ST_SCAN_END = 11'b00001000000,
		ST_TICK_ROW = 11'b00010000000,
		ST_REP_RD   = 11'b00100000000,
		ST_REP_CMP  = 11'b01000000000,
		ST_WAIT     = 11'b10000000000
	} state_t;

	state_t                    state_q;
	logic [3:0]                max_bind_q;
	logic [15:0]               timeout_q;
	logic [HOST_ROWS-1:0]      row_valid_q;
	logic [NSLOTS-1:0]         slot_valid_q;
	op_t                       op_q;
	logic [31:0]               host_q;
	logic [63:0]               sw_q;
	logic [15:0]               port_q;
	logic [31:0]               t_q;
	logic [31:0]               now_q;
	logic                      post_q;
	logic [ROWC_W-1:0]         rc_q;
	logic [ROW_W-1:0]          row_q;
	logic [ROW_W-1:0]          free_q;
	logic                      free_ok_q;
	logic [SC_W-1:0]           sc_q;
	logic [SLOT_W-1:0]         best_q;
	logic                      best_ok_q;
	slot_word_t                best_word_q;
	logic                      changed_q;
	logic [9:0]                expired_q;
	ev_t                       ev_q;
	logic                      out_valid_q;
	result_t                   res_q;

	store_req_t                req;
	logic [31:0]               rh_rdata;
	slot_word_t                sl_rdata;
	cmp_res_t                  cmp;
	logic [SLOTS_PER_HOST-1:0] row_vec;
	logic [SLOT_W-1:0]         sc_idx;
	logic [ROW_W-1:0]          rc_idx;
	logic [SC_W-1:0]           limit;
	logic                      higher;
	logic                      out_take;
	logic                      cfg_wr;

	assign sc_idx   = sc_q[SLOT_W-1:0];
	assign rc_idx   = rc_q[ROW_W-1:0];
	assign row_vec  = slot_valid_q[sidx(row_q, '0) +: SLOTS_PER_HOST];
	assign out_take = out_valid_q && !out_stall;
	assign cfg_wr   = psel && penable && pwrite;

	always_comb begin
		if (max_bind_q == 4'd0)
			limit = SC_W'(1);
		else if ({28'b0, max_bind_q} > 32'(SLOTS_PER_HOST))
			limit = SC_W'(SLOTS_PER_HOST);
		else
			limit = SC_W'(max_bind_q);
	end

	// Any valid slot above the current one means more results follow.
	always_comb begin
		higher = 1'b0;
		for (int j = 0; j < SLOTS_PER_HOST; j++)
			if (row_vec[j] && (SC_W'(j) > sc_q))
				higher = 1'b1;
	end

	always_comb begin
		req.rh_we    = (state_q == ST_NEWROW);
		req.rh_waddr = free_q;
		req.rh_wdata = host_q;
		req.rh_raddr = rc_idx;
		req.sl_wdata = '{sw: sw_q, port: port_q, seen: t_q};
		req.sl_raddr = sidx(row_q, sc_idx);
		req.sl_we    = 1'b0;
		req.sl_waddr = sidx(row_q, sc_idx);
		if (state_q == ST_NEWROW) begin
			req.sl_we    = 1'b1;
			req.sl_waddr = sidx(free_q, '0);
		end else if (state_q == ST_SCAN_CMP && op_q == OP_ADD && cmp.match) begin
			req.sl_we = 1'b1;
		end else if (state_q == ST_SCAN_END && op_q == OP_ADD && popcount(row_vec) < limit) begin
			req.sl_we    = 1'b1;
			req.sl_waddr = sidx(row_q, first_zero(row_vec));
		end
	end

	hlat_store u_store (
		.clk      (clk),
		.req      (req),
		.rh_rdata (rh_rdata),
		.sl_rdata (sl_rdata)
	);

	hlat_cmp u_cmp (
		.word      (sl_rdata),
		.sw        (sw_q),
		.port      (port_q),
		.best_time (best_word_q.seen),
		.timeout   (timeout_q),
		.now       (now_q),
		.res       (cmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_bind_q   <= 4'd1;
			timeout_q    <= 16'd60;
			row_valid_q  <= '0;
			slot_valid_q <= '0;
			op_q         <= OP_ADD;
			host_q       <= '0;
			sw_q         <= '0;
			port_q       <= '0;
			t_q          <= '0;
			now_q        <= '0;
			post_q       <= 1'b0;
			rc_q         <= '0;
			row_q        <= '0;
			free_q       <= '0;
			free_ok_q    <= 1'b0;
			sc_q         <= '0;
			best_q       <= '0;
			best_ok_q    <= 1'b0;
			best_word_q  <= '0;
			changed_q    <= 1'b0;
			expired_q    <= '0;
			ev_q         <= EV_NONE;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			if (cfg_wr) begin
				if (paddr[2] == REG_MAX_BINDINGS)
					max_bind_q <= pwdata[3:0];
				else
					timeout_q <= pwdata[15:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q      <= op_t'(kind);
						host_q    <= host_ip;
						sw_q      <= switch_id;
						port_q    <= port_num;
						t_q       <= (entry_time == 32'd0) ? current_time : entry_time;
						now_q     <= current_time;
						post_q    <= post_event;
						rc_q      <= '0;
						free_ok_q <= 1'b0;
						expired_q <= '0;
						state_q   <= (op_t'(kind) == OP_TICK) ? ST_TICK_ROW : ST_FIND_RD;
					end
				end
				ST_FIND_RD: begin
					if (rc_q == ROWC_W'(HOST_ROWS)) begin
						if (op_q == OP_ADD && free_ok_q) begin
							state_q <= ST_NEWROW;
						end else if (op_q == OP_ADD) begin
							res_q       <= mk_res(EV_NONE, host_q, 1'b0, '0, '0, 1'b1, 1'b1);
							out_valid_q <= 1'b1;
							state_q     <= ST_WAIT;
						end else if (op_q == OP_QUERY) begin
							res_q       <= mk_res(EV_NONE, host_q, 1'b0, '0, '0, 1'b0, 1'b1);
							out_valid_q <= 1'b1;
							state_q     <= ST_WAIT;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (!row_valid_q[rc_idx]) begin
						if (!free_ok_q) begin
							free_q    <= rc_idx;
							free_ok_q <= 1'b1;
						end
						rc_q <= rc_q + 1'b1;
					end else begin
						state_q <= ST_FIND_CMP;
					end
				end
				ST_FIND_CMP: begin
					if (rh_rdata == host_q) begin
						row_q     <= rc_idx;
						sc_q      <= '0;
						best_ok_q <= 1'b0;
						changed_q <= 1'b0;
						state_q   <= ST_SCAN_RD;
					end else begin
						rc_q    <= rc_q + 1'b1;
						state_q <= ST_FIND_RD;
					end
				end
				ST_NEWROW: begin
					row_valid_q[free_q] <= 1'b1;
					slot_valid_q[sidx(free_q, '0) +: SLOTS_PER_HOST] <= SLOTS_PER_HOST'(1);
					row_q   <= free_q;
					ev_q    <= EV_ADDED;
					sc_q    <= '0;
					state_q <= post_q ? ST_REP_RD : ST_IDLE;
				end
				ST_SCAN_RD: begin
					if (sc_q == SC_W'(SLOTS_PER_HOST))
						state_q <= ST_SCAN_END;
					else if (!row_vec[sc_idx])
						sc_q <= sc_q + 1'b1;
					else
						state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					sc_q    <= sc_q + 1'b1;
					state_q <= ST_SCAN_RD;
					case (op_q)
						OP_ADD: begin
							if (cmp.match) begin
								state_q <= ST_IDLE;
							end else if (!best_ok_q || cmp.older) begin
								best_q      <= sc_idx;
								best_ok_q   <= 1'b1;
								best_word_q <= sl_rdata;
							end
						end
						OP_REMOVE: begin
							if (cmp.match) begin
								slot_valid_q[sidx(row_q, sc_idx)] <= 1'b0;
								changed_q <= 1'b1;
							end
						end
						OP_TICK: begin
							if (cmp.expired) begin
								slot_valid_q[sidx(row_q, sc_idx)] <= 1'b0;
								if (expired_q != 10'h3FF)
									expired_q <= expired_q + 1'b1;
							end
						end
						default: begin
							if (!best_ok_q || cmp.newer) begin
								best_q      <= sc_idx;
								best_ok_q   <= 1'b1;
								best_word_q <= sl_rdata;
							end
						end
					endcase
				end
				ST_SCAN_END: begin
					sc_q <= '0;
					case (op_q)
						OP_ADD: begin
							if (popcount(row_vec) >= limit) begin
								// Drop the oldest location and look again.
								slot_valid_q[sidx(row_q, best_q)] <= 1'b0;
								best_ok_q <= 1'b0;
								state_q   <= ST_SCAN_RD;
							end else begin
								slot_valid_q[sidx(row_q, first_zero(row_vec))] <= 1'b1;
								ev_q    <= EV_MODIFIED;
								state_q <= post_q ? ST_REP_RD : ST_IDLE;
							end
						end
						OP_REMOVE: begin
							if (row_vec == '0)
								row_valid_q[row_q] <= 1'b0;
							if (changed_q && post_q && row_vec == '0) begin
								res_q       <= mk_res(EV_REMOVED, host_q, 1'b0, '0, '0, 1'b0, 1'b1);
								out_valid_q <= 1'b1;
								state_q     <= ST_WAIT;
							end else if (changed_q && post_q) begin
								ev_q    <= EV_MODIFIED;
								state_q <= ST_REP_RD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						OP_TICK: begin
							if (row_vec == '0)
								row_valid_q[row_q] <= 1'b0;
							rc_q    <= rc_q + 1'b1;
							state_q <= ST_TICK_ROW;
						end
						default: begin
							res_q       <= mk_res(EV_NONE, host_q, best_ok_q, best_word_q,
								'0, 1'b0, 1'b1);
							out_valid_q <= 1'b1;
							state_q     <= ST_WAIT;
						end
					endcase
				end
				ST_TICK_ROW: begin
					if (rc_q == ROWC_W'(HOST_ROWS)) begin
						res_q       <= mk_res(EV_NONE, '0, 1'b0, '0, expired_q, 1'b0, 1'b1);
						out_valid_q <= 1'b1;
						state_q     <= ST_WAIT;
					end else if (!row_valid_q[rc_idx]) begin
						rc_q <= rc_q + 1'b1;
					end else begin
						row_q   <= rc_idx;
						sc_q    <= '0;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_REP_RD: begin
					if (sc_q == SC_W'(SLOTS_PER_HOST))
						state_q <= ST_IDLE;
					else if (!row_vec[sc_idx])
						sc_q <= sc_q + 1'b1;
					else
						state_q <= ST_REP_CMP;
				end
				ST_REP_CMP: begin
					res_q       <= mk_res(ev_q, host_q, 1'b1, sl_rdata, '0, 1'b0, !higher);
					out_valid_q <= 1'b1;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_take) begin
						if (res_q.last) begin
							state_q <= ST_IDLE;
						end else begin
							sc_q    <= sc_q + 1'b1;
							state_q <= ST_REP_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == REG_TIMEOUT) ? {16'b0, timeout_q} : {28'b0, max_bind_q};
	assign out_valid     = out_valid_q;
	assign event_kind    = res_q.ev;
	assign host_out      = res_q.host;
	assign found         = res_q.found;
	assign switch_out    = res_q.loc.sw;
	assign port_out      = res_q.loc.port;
	assign time_out      = res_q.loc.seen;
	assign expired_count = res_q.expired;
	assign table_full    = res_q.full;
	assign last          = res_q.last;

endmodule

/* rtl/hlat_checker.sv */
// ----------------------------------------------------------------------------
// hlat_checker
// Port-level checks of the host location table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hlat_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] host_out,
	input logic        found,
	input logic [9:0]  expired_count,
	input logic        table_full,
	input logic        last
);

	// A result that waits keeps its contents.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(host_out))

	// No new request is taken while a result is pending.
	`ASSERT_SAME(a_busy, clk, arst_n, out_valid, in_stall)

	// A tick count only appears on a tick result, which has no host.
	`ASSERT_SAME(a_tick, clk, arst_n, out_valid && expired_count != 10'd0,
		host_out == 32'd0 && !found && last)

	// A dropped host gives a single result with no location.
	`ASSERT_SAME(a_full, clk, arst_n, out_valid && table_full, last && !found)

endmodule

bind host_location_aging_table_top hlat_checker u_hlat_checker (.*);
